### sv/pru_pkg.sv
// Shared constants, register indexes and the command type of the pixel replication upscaler.
package pru_pkg;

    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_SCALE   = 16;
    localparam int PIX_W       = 24;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = 11;
    localparam int SCALE_W     = 5;
    localparam int ROW_W       = 16;
    localparam int CNT_W       = $clog2(MAX_SCALE);
    localparam int PAD_W       = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE     = 2'd0,
        CFG_ROW_WIDTH = 2'd1,
        CFG_ROW_COUNT = 2'd2
    } cfg_index_t;

    // Input action codes.
    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_TICK  = 1'b1;

    // One classified command: emit copy_m1+1 copies of pixel.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic [CNT_W-1:0] copy_m1;
        logic             row_end;
        logic             image_end;
        logic             rejected;
        logic [PAD_W-1:0] pad;
    } cmd_t;

endpackage

### sv/pru_front.sv
// Front end: configuration, line store, row and replay counters, command generation.
module pru_front
    import pru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  cmd_valid,
    output cmd_t                  cmd,
    input  logic                  cmd_ready
);

    logic [SCALE_W-1:0] scale_reg;
    logic [WIDTH_W-1:0] row_width_reg;
    logic [ROW_W-1:0]   row_count_reg;

    logic [COL_W-1:0]   in_column_reg, in_column_next;
    logic [ROW_W-1:0]   in_row_reg, in_row_next;
    logic [CNT_W-1:0]   replay_left_reg, replay_left_next;
    logic [COL_W-1:0]   replay_column_reg, replay_column_next;

    logic [PIX_W-1:0]   line_store [MAX_WIDTH];
    logic [PIX_W-1:0]   rd_data_reg;

    logic               s2_valid_reg, s2_valid_next;
    cmd_t               s2_cmd_reg, s2_cmd_next;
    logic               s2_from_mem_reg;

    logic               accept;
    logic               produce;
    logic               wr_en;
    logic               rd_en;
    logic [SCALE_W-1:0] eff_scale;
    logic [WIDTH_W-1:0] eff_width;
    logic [ROW_W-1:0]   eff_rows;
    logic [PAD_W-1:0]   pad_val;
    logic [CNT_W-1:0]   copies_m1;
    logic               col_last;
    logic               rcol_last;
    logic               row_last;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg     <= SCALE_W'(1);
            row_width_reg <= WIDTH_W'(1);
            row_count_reg <= ROW_W'(1);
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_SCALE:     scale_reg     <= cfg_data[SCALE_W-1:0];
                CFG_ROW_WIDTH: row_width_reg <= cfg_data[WIDTH_W-1:0];
                CFG_ROW_COUNT: row_count_reg <= cfg_data[ROW_W-1:0];
                default:       ;
            endcase
        end
    end

    // Effective values with out-of-range settings clamped.
    always_comb
    begin
        if (scale_reg == '0)
            eff_scale = SCALE_W'(1);
        else if (scale_reg > SCALE_W'(MAX_SCALE))
            eff_scale = SCALE_W'(MAX_SCALE);
        else
            eff_scale = scale_reg;

        if (row_width_reg == '0)
            eff_width = WIDTH_W'(1);
        else if (row_width_reg > WIDTH_W'(MAX_WIDTH))
            eff_width = WIDTH_W'(MAX_WIDTH);
        else
            eff_width = row_width_reg;

        eff_rows = (row_count_reg == '0) ? ROW_W'(1) : row_count_reg;
    end

    // Output row bytes are 3*w*s; the pad to a multiple of four is (w*s) mod 4.
    assign pad_val   = eff_width[1:0] * eff_scale[1:0];
    assign copies_m1 = CNT_W'(eff_scale - SCALE_W'(1));

    assign col_last  = ({1'b0, in_column_reg} + WIDTH_W'(1)) >= eff_width;
    assign rcol_last = ({1'b0, replay_column_reg} + WIDTH_W'(1)) >= eff_width;
    assign row_last  = ({1'b0, in_row_reg} + (ROW_W+1)'(1)) >= {1'b0, eff_rows};

    // The stage register takes a new item when empty or when it moves on to the queue.
    assign accept    = push && !full;
    assign full      = s2_valid_reg && !cmd_ready;
    assign cmd_valid = s2_valid_reg;

    // Classify the accepted item and step the counters.
    always_comb
    begin
        in_column_next     = in_column_reg;
        in_row_next        = in_row_reg;
        replay_left_next   = replay_left_reg;
        replay_column_next = replay_column_reg;
        produce            = 1'b0;
        wr_en              = 1'b0;
        rd_en              = 1'b0;
        s2_cmd_next        = '0;
        s2_cmd_next.copy_m1 = copies_m1;

        if (accept)
        begin
            if (action == ACT_PIXEL)
            begin
                produce = 1'b1;
                if (replay_left_reg != '0)
                begin
                    // Pixel during replay: one rejected transfer.
                    s2_cmd_next.copy_m1  = '0;
                    s2_cmd_next.rejected = 1'b1;
                end
                else
                begin
                    wr_en             = 1'b1;
                    s2_cmd_next.pixel = pixel;
                    if (col_last)
                    begin
                        in_column_next     = '0;
                        replay_column_next = '0;
                        replay_left_next   = copies_m1;
                        s2_cmd_next.row_end = 1'b1;
                        s2_cmd_next.pad     = pad_val;
                        if (copies_m1 == '0)
                        begin
                            s2_cmd_next.image_end = row_last;
                            in_row_next = row_last ? '0 : in_row_reg + ROW_W'(1);
                        end
                    end
                    else
                    begin
                        in_column_next = in_column_reg + COL_W'(1);
                    end
                end
            end
            else if (replay_left_reg != '0)
            begin
                produce = 1'b1;
                rd_en   = 1'b1;
                if (rcol_last)
                begin
                    replay_column_next  = '0;
                    replay_left_next    = replay_left_reg - CNT_W'(1);
                    s2_cmd_next.row_end = 1'b1;
                    s2_cmd_next.pad     = pad_val;
                    if (replay_left_reg == CNT_W'(1))
                    begin
                        s2_cmd_next.image_end = row_last;
                        in_row_next = row_last ? '0 : in_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    replay_column_next = replay_column_reg + COL_W'(1);
                end
            end
        end

        if (accept)
            s2_valid_next = produce;
        else if (cmd_ready)
            s2_valid_next = 1'b0;
        else
            s2_valid_next = s2_valid_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_column_reg     <= '0;
            in_row_reg        <= '0;
            replay_left_reg   <= '0;
            replay_column_reg <= '0;
            s2_valid_reg      <= 1'b0;
        end
        else
        begin
            in_column_reg     <= in_column_next;
            in_row_reg        <= in_row_next;
            replay_left_reg   <= replay_left_next;
            replay_column_reg <= replay_column_next;
            s2_valid_reg      <= s2_valid_next;
        end
    end

    // Stage payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s2_cmd_reg      <= s2_cmd_next;
            s2_from_mem_reg <= rd_en;
        end
    end

    // Line store: one write and one registered read per cycle.
    always_ff @(posedge clk)
    begin
        if (wr_en)
            line_store[in_column_reg] <= pixel;
        if (rd_en)
            rd_data_reg <= line_store[replay_column_reg];
    end

    // Replayed commands take their pixel from the store read.
    always_comb
    begin
        cmd = s2_cmd_reg;
        if (s2_from_mem_reg)
            cmd.pixel = rd_data_reg;
    end

endmodule

### sv/pru_cmd_fifo.sv
// Short command queue between the front end and the copy engine.
module pru_cmd_fifo
    import pru_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_valid,
    output logic wr_ready,
    input  cmd_t wr_cmd,
    output logic rd_valid,
    output cmd_t rd_cmd,
    input  logic rd_pop
);

    localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t               slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic               do_wr;
    logic               do_rd;

    assign wr_ready = count_reg != COUNT_W'(QUEUE_DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_cmd   = slots[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_pop && rd_valid;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + COUNT_W'(1);
        else if (do_rd && !do_wr)
            count_next = count_reg - COUNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
            slots[wr_ptr_reg] <= wr_cmd;
    end

endmodule

### sv/pru_back.sv
// Copy engine: expands each command into the output register, one copy per cycle while pop allows.
module pru_back
    import pru_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    input  cmd_t             cmd,
    output logic             cmd_pop,
    output logic             empty,
    input  logic             pop,
    output logic [PIX_W-1:0] out_pixel,
    output logic [PAD_W-1:0] pad_bytes,
    output logic             row_end,
    output logic             image_end,
    output logic             rejected,
    output logic             last
);

    logic [CNT_W-1:0] copy_reg, copy_next;
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pixel_reg;
    logic [PAD_W-1:0] pad_bytes_reg;
    logic             row_end_reg;
    logic             image_end_reg;
    logic             rejected_reg;
    logic             last_reg;
    logic             advance;
    logic             fin;

    // A new copy is made whenever the output register is free or being drained.
    assign advance = cmd_valid && (!out_valid_reg || pop);
    assign fin     = copy_reg == cmd.copy_m1;
    assign cmd_pop = advance && fin;

    always_comb
    begin
        copy_next = copy_reg;
        if (advance)
            copy_next = fin ? '0 : copy_reg + CNT_W'(1);

        if (advance)
            out_valid_next = 1'b1;
        else if (pop)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            copy_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            copy_reg      <= copy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Output register; end marks go on the final copy only.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_pixel_reg <= cmd.pixel;
            pad_bytes_reg <= fin ? cmd.pad : '0;
            row_end_reg   <= fin && cmd.row_end;
            image_end_reg <= fin && cmd.image_end;
            rejected_reg  <= cmd.rejected;
            last_reg      <= fin;
        end
    end

    assign empty     = !out_valid_reg;
    assign out_pixel = out_pixel_reg;
    assign pad_bytes = pad_bytes_reg;
    assign row_end   = row_end_reg;
    assign image_end = image_end_reg;
    assign rejected  = rejected_reg;
    assign last      = last_reg;

endmodule

### sv/pixel_replication_upscaler.sv
// Top level of the pixel replication upscaler: front end, command queue and copy engine.
// Each transfer in is classified (pixel stored, replay tick read from the
// 1024-entry line store, or pixel rejected) and becomes a command in a four-entry queue;
// the copy engine turns a command into scale results (1 to 16; one for a rejected pixel,
// none for a tick while idle) at one result per cycle while the output is popped. The
// sustained input rate is set by the copy engine's single output register, though new
// items are taken while earlier ones are still copied. Input transfers are taken every
// cycle until the stage register and queue fill, and a result passes through the stage
// register, a queue slot and the output register. There is no clearing pass after reset.
module pixel_replication_upscaler
    import pru_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  push,
    output logic                  full,
    input  logic                  action,
    input  logic [PIX_W-1:0]      pixel,
    output logic                  empty,
    input  logic                  pop,
    output logic [PIX_W-1:0]      out_pixel,
    output logic [PAD_W-1:0]      pad_bytes,
    output logic                  row_end,
    output logic                  image_end,
    output logic                  rejected,
    output logic                  last
);

    logic fq_valid;
    logic fq_ready;
    cmd_t fq_cmd;
    logic bq_valid;
    logic bq_pop;
    cmd_t bq_cmd;

    // Classification and line store.
    pru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .action    (action),
        .pixel     (pixel),
        .cmd_valid (fq_valid),
        .cmd       (fq_cmd),
        .cmd_ready (fq_ready)
    );

    // Decoupling queue.
    pru_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_cmd   (fq_cmd),
        .rd_valid (bq_valid),
        .rd_cmd   (bq_cmd),
        .rd_pop   (bq_pop)
    );

    // Copy expansion and output register.
    pru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (bq_valid),
        .cmd       (bq_cmd),
        .cmd_pop   (bq_pop),
        .empty     (empty),
        .pop       (pop),
        .out_pixel (out_pixel),
        .pad_bytes (pad_bytes),
        .row_end   (row_end),
        .image_end (image_end),
        .rejected  (rejected),
        .last      (last)
    );

    // The image end mark only comes with a row end.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && image_end) |-> row_end)
        else $error("image_end without row_end");

    // A rejected pixel gives a single empty result.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && rejected) |-> (last && out_pixel == '0 && !row_end && pad_bytes == '0))
        else $error("malformed rejected result");

    // Pad bytes are reported only at the end of an output row.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pad_bytes != '0) |-> (row_end && last))
        else $error("pad bytes away from row end");

    // A row end always closes the copies of its item.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && row_end) |-> last)
        else $error("row_end on a non-final copy");

endmodule

### test/pixel_replication_upscaler_test.sv
// Self-checking testbench for the pixel replication upscaler: directed table, then random rows.
module pixel_replication_upscaler_test
    import pru_pkg::*;
();

    localparam int RANDOM_ITEMS  = 180;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 500000;

    // One result of the block, field by field.
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PAD_W-1:0] pad;
        logic             rend;
        logic             iend;
        logic             rej;
        logic             fin;
    } upscale_out_t;

    // How a row of the directed table is applied and checked.
    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_PREDICT,
        ROW_ONE,
        ROW_NONE
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] data;
        logic                  act;
        logic [PIX_W-1:0]      px;
        logic [4:0]            reps;
        upscale_out_t          res;
    } plan_row_t;

    localparam upscale_out_t NO_RES     = '0;
    localparam upscale_out_t REJECT_RES = '{24'h0, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1};

    // Directed stimulus: reset state, extremes of every register, rejection, idle tick,
    // out-of-range register values and a register write in the middle of a row.
    localparam int DIRECTED_ROWS = 23;
    localparam plan_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{ROW_ONE,     CFG_SCALE,     16'd0,     ACT_PIXEL, 24'hFFFFFF, 5'd1,
          '{24'hFFFFFF, 2'd1, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{ROW_NONE,    CFG_SCALE,     16'd0,     ACT_TICK,  24'hA5A5A5, 5'd1,  NO_RES},
        '{ROW_CFG,     CFG_SCALE,     16'd2,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_WIDTH, 16'd2,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_COUNT, 16'd2,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h123456, 5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_PIXEL, 24'hABCDEF, 5'd1,  NO_RES},
        '{ROW_ONE,     CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h555555, 5'd1,  REJECT_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_TICK,  24'h000000, 5'd2,  NO_RES},
        '{ROW_CFG,     CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_WIDTH, 16'd0,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_ONE,     CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h800001, 5'd1,
          '{24'h800001, 2'd1, 1'b1, 1'b1, 1'b0, 1'b1}},
        '{ROW_CFG,     CFG_SCALE,     16'd31,    ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_WIDTH, 16'd1,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_COUNT, 16'd0,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h0F0F0F, 5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_TICK,  24'hFFFFFF, 5'd15, NO_RES},
        '{ROW_CFG,     CFG_SCALE,     16'd1,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_WIDTH, 16'd2047,  ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_CFG,     CFG_ROW_COUNT, 16'd65535, ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h000000, 5'd2,  NO_RES},
        '{ROW_CFG,     CFG_ROW_WIDTH, 16'd1,     ACT_PIXEL, 24'h0,      5'd1,  NO_RES},
        '{ROW_PREDICT, CFG_SCALE,     16'd0,     ACT_PIXEL, 24'h7E8C13, 5'd1,  NO_RES}
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  push = 1'b0;
    logic                  full;
    logic                  action = 1'b0;
    logic [PIX_W-1:0]      pixel = '0;
    logic                  empty;
    logic                  pop = 1'b0;
    logic [PIX_W-1:0]      out_pixel;
    logic [PAD_W-1:0]      pad_bytes;
    logic                  row_end;
    logic                  image_end;
    logic                  rejected;
    logic                  last;

    // Shadow registers and upscaler state, at their reset values.
    logic [SCALE_W-1:0] reg_scale = 5'd1;
    logic [WIDTH_W-1:0] reg_width = 11'd1;
    logic [ROW_W-1:0]   reg_rows = 16'd1;
    logic [PIX_W-1:0]   line_mem [MAX_WIDTH];
    int                 col_in = 0;
    int                 row_in = 0;
    int                 replays_left = 0;
    int                 col_replay = 0;
    int                 cols_filled = 0;

    upscale_out_t new_results [$];
    upscale_out_t pending_out [$];
    int           mismatches = 0;
    int           burst_left = 0;
    int           stall_mode = 0;
    int           stall_left = 0;
    int           stall_tick = 0;
    int           cycle_count = 0;

    pixel_replication_upscaler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .full      (full),
        .action    (action),
        .pixel     (pixel),
        .empty     (empty),
        .pop       (pop),
        .out_pixel (out_pixel),
        .pad_bytes (pad_bytes),
        .row_end   (row_end),
        .image_end (image_end),
        .rejected  (rejected),
        .last      (last)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Effective enlargement factor and row width after range limiting.
    function automatic int clamp_scale(input logic [SCALE_W-1:0] s);
        if (s == '0)
            return 1;
        if (int'(s) > MAX_SCALE)
            return MAX_SCALE;
        return int'(s);
    endfunction

    function automatic int clamp_width(input logic [WIDTH_W-1:0] w);
        if (w == '0)
            return 1;
        if (int'(w) > MAX_WIDTH)
            return MAX_WIDTH;
        return int'(w);
    endfunction

    // Zero bytes that bring an output row of 3 * width * scale bytes to a multiple of 4.
    function automatic int pad_needed();
        int bytes;
        bytes = 3 * clamp_width(reg_width) * clamp_scale(reg_scale);
        return (4 - bytes % 4) % 4;
    endfunction

    // An input row has been fully emitted; returns whether it closed the image.
    function automatic bit close_row();
        bit iend;
        int rows;
        rows = (reg_rows == '0) ? 1 : int'(reg_rows);
        iend = (row_in + 1 >= rows);
        row_in = iend ? 0 : row_in + 1;
        return iend;
    endfunction

    // Queue n copies of a pixel; the final copy carries the end marks.
    function automatic void emit_copies(input logic [PIX_W-1:0] px, input int n,
                                        input bit rend, input bit iend);
        upscale_out_t r;
        for (int k = 0; k < n; k++)
        begin
            r.px   = px;
            r.pad  = (k == n - 1 && rend) ? PAD_W'(pad_needed()) : '0;
            r.rend = (k == n - 1 && rend);
            r.iend = (k == n - 1 && rend && iend);
            r.rej  = 1'b0;
            r.fin  = (k == n - 1);
            new_results.push_back(r);
        end
    endfunction

    // Results caused by one accepted item: store-and-copy, replay, or rejection.
    function automatic void upscale_item(input logic act, input logic [PIX_W-1:0] px);
        int n;
        int w;
        bit rend;
        bit iend;
        n = clamp_scale(reg_scale);
        w = clamp_width(reg_width);
        iend = 1'b0;
        new_results.delete();
        if (act == ACT_PIXEL)
        begin
            if (replays_left != 0)
            begin
                new_results.push_back(REJECT_RES);
                return;
            end
            line_mem[col_in] = px;
            if (col_in + 1 > cols_filled)
                cols_filled = col_in + 1;
            rend = (col_in + 1 >= w);
            if (rend)
            begin
                col_in = 0;
                col_replay = 0;
                replays_left = n - 1;
                if (replays_left == 0)
                    iend = close_row();
            end
            else
                col_in++;
            emit_copies(px, n, rend, iend);
        end
        else if (replays_left != 0)
        begin
            px = line_mem[col_replay];
            rend = (col_replay + 1 >= w);
            if (rend)
            begin
                col_replay = 0;
                replays_left--;
                if (replays_left == 0)
                    iend = close_row();
            end
            else
                col_replay++;
            emit_copies(px, n, rend, iend);
        end
    endfunction

    // Register write; the write enable stays high for a following write.
    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            CFG_SCALE:     reg_scale = data[SCALE_W-1:0];
            CFG_ROW_WIDTH: reg_width = data[WIDTH_W-1:0];
            default:       reg_rows  = data[ROW_W-1:0];
        endcase
    endtask

    // Input transfer in bursts with random gaps; expectations are queued on acceptance.
    task automatic send_item(input logic act, input logic [PIX_W-1:0] px,
                             input step_kind_t kind, input upscale_out_t typed);
        cfg_write <= 1'b0;
        if (burst_left == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        push   <= 1'b1;
        action <= act;
        pixel  <= px;
        do
            @(posedge clk);
        while (full);
        upscale_item(act, px);
        case (kind)
            ROW_ONE:     pending_out.push_back(typed);
            ROW_PREDICT: foreach (new_results[k]) pending_out.push_back(new_results[k]);
            default:     ;
        endcase
    endtask

    // Stop sending and let every expected result drain, plus the pipeline tail.
    task automatic wait_idle();
        push      <= 1'b0;
        cfg_write <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_out.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [PIX_W-1:0] want,
                               input logic [PIX_W-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            mismatches++;
        end
    endtask

    // Result side: compare each transfer with the oldest expectation, stall in patterns.
    always @(posedge clk)
    begin
        upscale_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_out.size() == 0)
            begin
                $error("out_pixel: expected no result, actual %0h", out_pixel);
                mismatches++;
            end
            else
            begin
                want = pending_out.pop_front();
                check_field("out_pixel", want.px, out_pixel);
                check_field("pad_bytes", PIX_W'(want.pad), PIX_W'(pad_bytes));
                check_field("row_end", PIX_W'(want.rend), PIX_W'(row_end));
                check_field("image_end", PIX_W'(want.iend), PIX_W'(image_end));
                check_field("rejected", PIX_W'(want.rej), PIX_W'(rejected));
                check_field("last", PIX_W'(want.fin), PIX_W'(last));
            end
        end
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(8, 64);
        end
        stall_left--;
        stall_tick++;
        case (stall_mode)
            0:       pop <= 1'b1;
            1:       pop <= ($urandom_range(0, 1) == 1);
            2:       pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (stall_tick % 5 != 0);
        endcase
    end

    // Watchdog on the whole run.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pixel_replication_upscaler_test failed");
        $finish;
    end

    initial
    begin
        plan_row_t             row_plan;
        bit                    prev_cfg;
        logic                  act;
        logic [PIX_W-1:0]      px;
        logic [CFG_DATA_W-1:0] v;
        int                    busy_items;
        int                    phase_len;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        prev_cfg = 1'b0;
        foreach (DIRECTED_PLAN[i])
        begin
            row_plan = DIRECTED_PLAN[i];
            if (row_plan.kind == ROW_CFG)
            begin
                if (!prev_cfg)
                    wait_idle();
                write_reg(row_plan.idx, row_plan.data);
            end
            else
            begin
                repeat (int'(row_plan.reps))
                    send_item(row_plan.act, row_plan.px, row_plan.kind, row_plan.res);
            end
            prev_cfg = (row_plan.kind == ROW_CFG);
        end

        // Random phases: new settings while idle, then mostly well-formed rows and replays.
        busy_items = 0;
        while (busy_items < RANDOM_ITEMS)
        begin
            wait_idle();
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 9))
                    0:       v = 16'd0;
                    1:       v = 16'd31;
                    2:       v = 16'd16;
                    3:       v = 16'($urandom_range(17, 31));
                    default: v = 16'($urandom_range(1, 4));
                endcase
                write_reg(CFG_SCALE, v);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 11))
                    0:       v = 16'd0;
                    1:       v = 16'd1024;
                    2:       v = 16'd2047;
                    3:       v = 16'($urandom_range(7, 40));
                    default: v = 16'($urandom_range(1, 6));
                endcase
                // A replay in progress must never reach columns that were never stored.
                if (replays_left != 0 && clamp_width(v[WIDTH_W-1:0]) > cols_filled)
                    v = 16'(cols_filled);
                write_reg(CFG_ROW_WIDTH, v);
            end
            if ($urandom_range(0, 1) == 1)
            begin
                case ($urandom_range(0, 7))
                    0:       v = 16'd0;
                    1:       v = 16'd65535;
                    2:       v = 16'($urandom_range(4, 65535));
                    default: v = 16'($urandom_range(1, 3));
                endcase
                write_reg(CFG_ROW_COUNT, v);
            end
            phase_len = $urandom_range(4, 30);
            repeat (phase_len)
            begin
                if (replays_left != 0)
                    act = ($urandom_range(0, 9) != 0) ? ACT_TICK : ACT_PIXEL;
                else
                    act = ($urandom_range(0, 15) == 0) ? ACT_TICK : ACT_PIXEL;
                case ($urandom_range(0, 9))
                    0:       px = '0;
                    1:       px = '1;
                    default: px = PIX_W'($urandom);
                endcase
                if (!(act == ACT_TICK && replays_left == 0))
                    busy_items++;
                send_item(act, px, ROW_PREDICT, NO_RES);
            end
        end

        wait_idle();
        if (mismatches == 0)
            $display("pixel_replication_upscaler_test passed");
        else
            $display("pixel_replication_upscaler_test failed");
        $finish;
    end

endmodule
